/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the base64 codec
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define B64_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("base64 codec: assertion failed");

// Expression must never be true outside reset.
`define B64_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("base64 codec: forbidden condition seen");

`else

`define B64_ASSERT(lbl, clk, rst_n, prop)
`define B64_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

/* src/b64_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 codec package
// Shared types, constants and alphabet functions of the codec.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam logic [7:0] PadChar = 8'h3D;

  // Depth of the job queue between front and back.
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // One accepted item turned into up to four result beats.
  typedef struct packed {
    logic [3:0][7:0] data;    // result bytes, slot 0 goes out first
    logic [1:0]      cnt;     // number of beats minus one
    logic            dvalid;  // 0 only for the empty end marker
    logic            last;    // final beat carries out_last
    logic            err;     // sticky error as seen after this item
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Six-bit value to alphabet character.
  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] r;
    case (s) inside
      [6'd0:6'd25]:  r = {2'b00, s} + 8'h41;
      [6'd26:6'd51]: r = {2'b00, s} + 8'd71;
      [6'd52:6'd61]: r = {2'b00, s} - 8'd4;
      6'd62:         r = 8'h2B;
      default:       r = 8'h2F;
    endcase
    return r;
  endfunction

  // Character to six-bit value; bit 6 set when the character is not in the alphabet.
  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [6:0] r;
    case (c) inside
      [8'h41:8'h5A]: r = {1'b0, 6'(c - 8'h41)};
      [8'h61:8'h7A]: r = {1'b0, 6'(c - 8'd71)};
      [8'h30:8'h39]: r = {1'b0, 6'(c + 8'd4)};
      8'h2B:         r = {1'b0, 6'd62};
      8'h2F:         r = {1'b0, 6'd63};
      default:       r = 7'h40;
    endcase
    return r;
  endfunction

endpackage

/* src/b64_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 codec channel interfaces
// Valid/ready channels for input items and result beats.
// ----------------------------------------------------------------------------
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;
  logic       bad_input;

  modport source (output valid, out_byte, out_valid, out_last, bad_input, input ready);
  modport sink   (input valid, out_byte, out_valid, out_last, bad_input, output ready);
endinterface

/* src/b64_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 codec front end
// Accepts items, updates the group state and builds one job per item.
// ----------------------------------------------------------------------------
module b64_front import b64_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  b64_in_if.sink     in_i,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic            mode_q;
  logic [5:0]      acc_q, acc_d;
  logic [1:0]      pos_q, pos_d;
  logic            pad_q, pad_d;
  logic            err_q, err_d;
  logic            accept;
  logic [7:0]      b;
  logic            last;
  logic [6:0]      sext;
  logic [3:0][7:0] data;
  logic [2:0]      n;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign b          = in_i.in_byte;
  assign last       = in_i.in_last;
  assign sext       = b64_sextet(b);

  always_comb begin
    acc_d = acc_q;
    pos_d = pos_q;
    pad_d = pad_q;
    err_d = err_q;
    data  = '0;
    n     = 3'd0;
    if (!mode_q) begin
      case (pos_q)
        2'd1: begin
          data[0] = b64_char({acc_q[1:0], b[7:4]});
          acc_d   = {2'b00, b[3:0]};
          pos_d   = 2'd2;
          n       = 3'd1;
          if (last) begin
            data[1] = b64_char({b[3:0], 2'b00});
            data[2] = PadChar;
            n       = 3'd3;
          end
        end
        2'd2: begin
          data[0] = b64_char({acc_q[3:0], b[7:6]});
          data[1] = b64_char(b[5:0]);
          acc_d   = '0;
          pos_d   = 2'd0;
          n       = 3'd2;
        end
        default: begin
          // Position three cannot occur in encode mode; it acts as zero.
          data[0] = b64_char(b[7:2]);
          acc_d   = {4'b0000, b[1:0]};
          pos_d   = 2'd1;
          n       = 3'd1;
          if (last) begin
            data[1] = b64_char({b[1:0], 4'b0000});
            data[2] = PadChar;
            data[3] = PadChar;
            n       = 3'd4;
          end
        end
      endcase
    end else begin
      if (pad_q) begin
        // Everything after the pad is dropped silently.
      end else if (b == PadChar) begin
        if (pos_q < 2'd2) begin
          err_d = 1'b1;
        end
        pad_d = 1'b1;
      end else if (sext[6]) begin
        err_d = 1'b1;
      end else begin
        acc_d = sext[5:0];
        pos_d = pos_q + 2'd1;
        case (pos_q)
          2'd1: begin
            data[0] = {acc_q, sext[5:4]};
            n       = 3'd1;
          end
          2'd2: begin
            data[0] = {acc_q[3:0], sext[5:2]};
            n       = 3'd1;
          end
          2'd3: begin
            data[0] = {acc_q[1:0], sext[5:0]};
            acc_d   = '0;
            n       = 3'd1;
          end
          default: begin
          end
        endcase
      end
      // A message that ends on a lone character is incomplete.
      if (last && !pad_d && pos_d == 2'd1) begin
        err_d = 1'b1;
      end
    end

    job_o.data   = data;
    job_o.dvalid = (n != 3'd0);
    job_o.cnt    = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
    job_o.last   = last;
    job_o.err    = err_d;

    if (last) begin
      acc_d = '0;
      pos_d = '0;
      pad_d = 1'b0;
    end
  end

  assign push_o = accept && (n != 3'd0 || last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      acc_q  <= '0;
      pos_q  <= '0;
      pad_q  <= 1'b0;
      err_q  <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
      acc_q  <= '0;
      pos_q  <= '0;
      pad_q  <= 1'b0;
      err_q  <= 1'b0;
    end else if (accept) begin
      acc_q <= acc_d;
      pos_q <= pos_d;
      pad_q <= pad_d;
      err_q <= err_d;
    end
  end

endmodule

/* src/b64_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 codec job queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module b64_queue import b64_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output q_stat_t stat_o,
  output job_t    head_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rptr_q];

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ptr_inc(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= ptr_inc(rptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* src/b64_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 codec back end
// Plays each job out as one result beat per cycle from a held register while out ready is high.
// ----------------------------------------------------------------------------
module b64_back import b64_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_stat_t stat_i,
  input  job_t    head_i,
  output logic    pop_o,
  b64_out_if.source out_o
);

  job_t       cur_q;
  logic [1:0] idx_q;
  logic       busy_q;
  logic       beat;
  logic       done;
  logic       at_end;

  assign at_end = (idx_q == cur_q.cnt);
  assign beat   = busy_q && out_o.ready;
  assign done   = beat && at_end;
  assign pop_o  = (!busy_q || done) && !stat_i.empty;

  assign out_o.valid     = busy_q;
  assign out_o.out_byte  = cur_q.data[idx_q];
  assign out_o.out_valid = cur_q.dvalid;
  assign out_o.out_last  = cur_q.last && at_end;
  assign out_o.bad_input = cur_q.err;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (beat) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

/* src/base64_codec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 codec top level
// Streaming standard-alphabet base64 encoder and decoder with '=' padding.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake      Beat contents
//   in_i      in    valid/ready    in_byte, in_last
//   out_o     out   valid/ready    out_byte, out_valid, out_last, bad_input
//   cfg       in    cfg_we_i only  cfg_wdata_i = decode_mode
//
// The front end takes one input beat per cycle whenever the job queue has
// room and turns it into one job of up to four result beats in that cycle.
// The back end sends one result beat per cycle while the receiver is ready;
// its one-beat-per-cycle port sets the sustained rate, and the two-entry
// queue lets the input keep flowing while a long job drains. An input beat
// is registered in the job queue and then in the back end's job register
// before its first result appears. Reset is asynchronous and active low and
// needs no clearing pass; a configuration write clears the group state and
// the sticky error flag and is meant to happen only while the codec is idle.
//
module base64_codec import b64_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  b64_in_if.sink    in_i,
  b64_out_if.source out_o
);

  `include "assert_macros.svh"

  // Job handoff between front end, queue and back end.
  logic    push;
  logic    pop;
  job_t    job_new;
  job_t    job_head;
  q_stat_t q_stat;

  // The front end classifies each character or byte and computes every
  // result beat the item causes, together with the updated sticky error.
  b64_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_stat.full),
    .push_o      (push),
    .job_o       (job_new)
  );

  // Items that cause no result never enter the queue, except a final item, which enters as an empty end marker.
  b64_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_new),
    .pop_i  (pop),
    .stat_o (q_stat),
    .head_o (job_head)
  );

  // The back end holds the current job in registers and steps through it.
  b64_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (q_stat),
    .head_i (job_head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  // The front end must never push into a full queue.
  `B64_NEVER(a_queue_no_overflow, clk_i, rst_ni, push && q_stat.full)

  // An idle back end picks up a waiting job on the next edge.
  `B64_ASSERT(a_back_takes_job, clk_i, rst_ni, (!q_stat.empty && !out_o.valid) |=> out_o.valid)

  // An empty end marker is only ever sent as the final beat of a message.
  `B64_ASSERT(a_marker_is_last, clk_i, rst_ni,
              (out_o.valid && !out_o.out_valid) |-> out_o.out_last)

endmodule

/* bench/tb_base64_codec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 codec testbench
// Drives byte and character beats into the codec in both directions, works
// out the expected result beats with an independent bit-level predictor and
// checks every result beat field by field under random back-pressure.
// ----------------------------------------------------------------------------
module tb_base64_codec;
  import b64_pkg::*;

  // Input beat as queued for the driver.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } codec_item_t;

  // Result beat as the codec should send it.
  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       last;
    logic       err;
  } codec_beat_t;

  // Cycles without any accepted beat before the run is abandoned. The slowest
  // legal stretch is the long receiver hold-off of HoldCycles plus a settle
  // pause, so this leaves a wide margin.
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 80;
  localparam int SettleCycles = 8;

  localparam logic [511:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  b64_in_if  in_if ();
  b64_out_if out_if ();

  base64_codec dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  codec_item_t codec_items[$];     // beats waiting to be offered
  codec_beat_t codec_beats_due[$]; // result beats predicted, not yet seen

  int fail_cnt = 0;
  int tx_idle_pct;
  int rx_idle_pct;
  int quiet_cycles;
  int hold_left;
  logic hold_arm;

  // Predictor state, mirroring the codec's group state and its register.
  logic        pm_decode;
  logic [23:0] pm_acc;
  logic [1:0]  pm_pos;
  logic        pm_pad;
  logic        pm_err;

  function automatic logic [7:0] enc_char(input logic [5:0] s);
    return Alphabet[511 - 8 * s -: 8];
  endfunction

  // Six-bit value of a character; bit 6 flags a character outside the alphabet.
  function automatic logic [6:0] char_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return {1'b0, 6'(c - 8'h41)};
    if (c >= "a" && c <= "z") return {1'b0, 6'(c - 8'h61 + 8'd26)};
    if (c >= "0" && c <= "9") return {1'b0, 6'(c - 8'h30 + 8'd52)};
    if (c == "+") return 7'd62;
    if (c == "/") return 7'd63;
    return 7'h40;
  endfunction

  // Works out the result beats of one accepted input beat and queues them.
  function automatic void compute_codec_beats(input logic [7:0] b, input logic lst);
    logic [7:0] vals [4];
    logic [6:0] sx;
    logic [1:0] p;
    int n;
    n = 0;
    if (!pm_decode) begin
      // A group position of three cannot occur here; it counts as zero.
      p = (pm_pos == 2'd3) ? 2'd0 : pm_pos;
      pm_acc = {pm_acc[15:0], b};
      case (p)
        2'd0: begin
          vals[0] = enc_char(pm_acc[7:2]);
          n = 1;
          pm_acc = {22'd0, pm_acc[1:0]};
          if (lst) begin
            vals[1] = enc_char({pm_acc[1:0], 4'd0});
            vals[2] = PadChar;
            vals[3] = PadChar;
            n = 4;
          end
        end
        2'd1: begin
          vals[0] = enc_char(pm_acc[9:4]);
          n = 1;
          pm_acc = {20'd0, pm_acc[3:0]};
          if (lst) begin
            vals[1] = enc_char({pm_acc[3:0], 2'd0});
            vals[2] = PadChar;
            n = 3;
          end
        end
        default: begin
          vals[0] = enc_char(pm_acc[11:6]);
          vals[1] = enc_char(pm_acc[5:0]);
          n = 2;
          pm_acc = '0;
        end
      endcase
      pm_pos = (p == 2'd2) ? 2'd0 : p + 2'd1;
    end else begin
      // Once the pad is seen the rest of the message is dropped silently.
      if (!pm_pad) begin
        if (b == PadChar) begin
          if (pm_pos < 2'd2) pm_err = 1'b1;
          pm_pad = 1'b1;
        end else begin
          sx = char_value(b);
          if (sx[6]) begin
            pm_err = 1'b1;
          end else begin
            pm_acc = {pm_acc[17:0], sx[5:0]};
            case (pm_pos)
              2'd1: begin
                vals[0] = pm_acc[11:4];
                n = 1;
              end
              2'd2: begin
                vals[0] = pm_acc[9:2];
                n = 1;
              end
              2'd3: begin
                vals[0] = pm_acc[7:0];
                n = 1;
                pm_acc = '0;
              end
              default: ;
            endcase
            pm_pos = pm_pos + 2'd1;
          end
        end
      end
      // A lone character left in the final group cannot form a byte.
      if (lst && !pm_pad && pm_pos == 2'd1) pm_err = 1'b1;
    end
    for (int k = 0; k < n; k++)
      codec_beats_due.push_back('{vals[k], 1'b1, lst && (k == n - 1), pm_err});
    if (lst) begin
      if (n == 0) codec_beats_due.push_back('{8'd0, 1'b0, 1'b1, pm_err});
      pm_acc = '0;
      pm_pos = '0;
      pm_pad = 1'b0;
    end
  endfunction

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      fail_cnt++;
    end
  endtask

  // Driver: a beat stays on the bus until it is taken; a new one is offered
  // only once the slot is free, with random gaps between beats.
  always @(posedge clk_i) begin : drive_proc
    codec_item_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) compute_codec_beats(in_if.in_byte, in_if.in_last);
      if (!in_if.valid || in_if.ready) begin
        if (codec_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = codec_items.pop_front();
          in_if.valid   <= 1'b1;
          in_if.in_byte <= nxt.data;
          in_if.in_last <= nxt.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result beat against the oldest prediction
  // and drives ready, including one long hold-off that fills the codec.
  always @(posedge clk_i) begin : watch_proc
    codec_beat_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (codec_beats_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h/%b/%b/%b",
                   $time, out_if.out_byte, out_if.out_valid, out_if.out_last,
                   out_if.bad_input);
          fail_cnt++;
        end else begin
          want = codec_beats_due.pop_front();
          check_field("out_byte", want.data, out_if.out_byte);
          check_field("out_valid", {7'd0, want.dvalid}, {7'd0, out_if.out_valid});
          check_field("out_last", {7'd0, want.last}, {7'd0, out_if.out_last});
          check_field("bad_input", {7'd0, want.err}, {7'd0, out_if.bad_input});
        end
      end
      if (hold_arm && hold_left == 0) hold_left <= HoldCycles;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      out_if.ready <= (hold_left == 0) && !hold_arm && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog on cycles with no beat accepted on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == StallLimit) begin
      $display("%0t: no beat accepted for %0d cycles", $time, StallLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] d, input logic l);
    codec_items.push_back('{d, l});
  endtask

  // Waits until every queued beat went in and every result came out, then
  // lets the codec settle before anything else happens.
  task automatic wait_drained();
    while (codec_items.size() != 0 || in_if.valid || codec_beats_due.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Register write while idle; it also clears the group state and the error.
  task automatic write_mode(input logic m);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pm_decode = m;
    pm_acc    = '0;
    pm_pos    = '0;
    pm_pad    = 1'b0;
    pm_err    = 1'b0;
    @(negedge clk_i);
  endtask

  task automatic push_encode_msgs(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) push_item(8'($urandom_range(0, 255)), i == len - 1);
      sent += len;
    end
  endtask

  // Well-formed messages with random data, some altered to unpadded ends, stray
  // characters or trailing junk, plus random bytes, lone final characters and misplaced pads.
  task automatic push_decode_msgs(input int n_items);
    logic [7:0] raw[$];
    logic [7:0] chars[$];
    logic [7:0] b0, b1, b2, nz;
    logic [6:0] sx;
    int sent, kind, nb;
    sent = 0;
    while (sent < n_items) begin
      raw.delete();
      chars.delete();
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        nb = $urandom_range(1, 7);
        for (int i = 0; i < nb; i++) raw.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < nb; i += 3) begin
          b0 = raw[i];
          b1 = (i + 1 < nb) ? raw[i + 1] : 8'd0;
          b2 = (i + 2 < nb) ? raw[i + 2] : 8'd0;
          chars.push_back(enc_char(b0[7:2]));
          chars.push_back(enc_char({b0[1:0], b1[7:4]}));
          chars.push_back((i + 1 < nb) ? enc_char({b1[3:0], b2[7:6]}) : PadChar);
          chars.push_back((i + 2 < nb) ? enc_char(b2[5:0]) : PadChar);
        end
        if (kind == 6)
          while (chars.size() > 1 && chars[$] == PadChar) void'(chars.pop_back());
        if (kind == 5) begin
          do begin
            nz = 8'($urandom_range(0, 255));
            sx = char_value(nz);
          end while (!sx[6] || nz == PadChar);
          chars.insert($urandom_range(0, chars.size() - 1), nz);
        end
        if (kind == 4)
          repeat ($urandom_range(1, 2)) chars.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 7) begin
        repeat (5) chars.push_back(enc_char(6'($urandom_range(0, 63))));
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 4)) chars.push_back(8'($urandom_range(0, 255)));
      end else begin
        chars.push_back(enc_char(6'($urandom_range(0, 63))));
        chars.push_back(PadChar);
        chars.push_back(8'($urandom_range(0, 255)));
      end
      for (int i = 0; i < chars.size(); i++) push_item(chars[i], i == chars.size() - 1);
      sent += chars.size();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'd0;
    in_if.in_last = 1'b0;
    out_if.ready  = 1'b0;
    hold_arm      = 1'b0;
    tx_idle_pct   = 24;
    rx_idle_pct   = 82;
    pm_decode     = 1'b0;
    pm_acc        = '0;
    pm_pos        = '0;
    pm_pad        = 1'b0;
    pm_err        = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Encode straight out of reset: one-, two- and four-byte messages,
    // the four-byte one opening with a group of sextets 62 and 63.
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'h80, 1'b1);
    push_item(8'hFB, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hBF, 1'b0);
    push_item(8'h7F, 1'b1);
    wait_drained();

    // Decode: a full quad, a pad followed by ignored items and an end
    // marker, unpadded ends of two and three characters, then the error
    // cases: a lone final character, a misplaced pad and invalid characters.
    write_mode(1'b1);
    push_item("T", 1'b0);
    push_item("W", 1'b0);
    push_item("F", 1'b0);
    push_item("u", 1'b0);
    push_item("T", 1'b0);
    push_item("Q", 1'b0);
    push_item("=", 1'b0);
    push_item("x", 1'b0);
    push_item("=", 1'b1);
    push_item("T", 1'b0);
    push_item("W", 1'b1);
    push_item("/", 1'b0);
    push_item("+", 1'b0);
    push_item("8", 1'b1);
    push_item("T", 1'b1);
    push_item("=", 1'b0);
    push_item("0", 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b1);
    wait_drained();

    // Random traffic, slow receiver.
    write_mode(1'b0);
    push_encode_msgs(20);
    wait_drained();
    write_mode(1'b1);
    push_decode_msgs(20);
    wait_drained();

    // Random traffic, slow sender; a rewrite of the same mode mid-way clears
    // the sticky error.
    tx_idle_pct = 82;
    rx_idle_pct = 24;
    write_mode(1'b0);
    push_encode_msgs(20);
    wait_drained();
    write_mode(1'b1);
    push_decode_msgs(10);
    wait_drained();
    write_mode(1'b1);
    push_decode_msgs(10);
    wait_drained();

    // Full rate, with one long receiver hold-off while the sender keeps
    // offering beats, so the job queue fills and input ready drops.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_mode(1'b0);
    push_encode_msgs(15);
    hold_arm = 1'b1;
    while (hold_left == 0) @(negedge clk_i);
    hold_arm = 1'b0;
    wait_drained();
    write_mode(1'b1);
    push_decode_msgs(15);
    wait_drained();

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
